@@ src/thh_pkg.sv @@
// package for the thermistor hysteresis heater: constants, codes and state type
`default_nettype none
package thh_pkg;

  localparam int ADC_BITS = 12;
  localparam int IN_W     = ((ADC_BITS + 7) / 8) * 8;
  localparam int KW       = $clog2(ADC_BITS);
  localparam int LN_W     = 40;
  localparam int MAG_W    = 48;
  localparam int REM_W    = 62;
  localparam int QB       = 24;

  localparam logic [31:0]       LN2_Q32    = 32'hB17217F7;
  localparam logic [LN_W-1:0]   LN_1E5_Q32 = 40'd49447638353;
  localparam logic signed [27:0] KELVIN_Q8 = 28'sd1118822;
  localparam logic signed [27:0] HALF_LSB  = 28'sd128;
  localparam logic [63:0]       DIV_LIM    = 64'd68719476736;
  localparam logic [REM_W-1:0]  REM_INIT   = 62'd68719476736;

  typedef enum logic [2:0] {
    CFG_COEF_A  = 3'd0,
    CFG_COEF_B  = 3'd1,
    CFG_COEF_C  = 3'd2,
    CFG_TARGET  = 3'd3,
    CFG_BAND    = 3'd4,
    CFG_ENABLE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_L2,
    JOB_L3,
    JOB_BL,
    JOB_CL3
  } mul_job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LN_INIT,
    ST_LN_SQ,
    ST_LN_FR,
    ST_LN_ACC,
    ST_MUL,
    ST_MUL_WB,
    ST_DIV_INIT,
    ST_DIV,
    ST_CONV,
    ST_UPD,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

@@ src/thermistor_hysteresis_heater.sv @@
// Thermistor channel: an accepted sample passes through two 33-step log loops on the shared
// 32x32 multiplier, four 5-step products on the same multiplier and a 24-step restoring
// divider; a disabled channel or a zero sample goes straight to the output stage. The input
// side is ready only while no sample is being converted, and a new sample may be taken while
// the previous result still waits at the output. Coefficients, setpoint, band and enable
// must be written through the cfg port while idle; the block itself does not enforce it.
`default_nettype none
module thermistor_hysteresis_heater
  import thh_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,   // adc_sample
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata,  // temperature, heater_drive
  output logic                 out_tuser,  // sensor_fault
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [47:0]     cfg_wdata
);

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0] adc_r, adc_nxt;
  logic ln_sel_r, ln_sel_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [35:0] kln_r, kln_nxt;
  logic [63:0] p_r, p_nxt;
  logic [1:0] pidx_r, pidx_nxt;
  logic [LN_W-1:0] l_r, l_nxt;
  logic [MAG_W-1:0] l3_r, l3_nxt, ma_r, ma_nxt, mb_r, mb_nxt;
  logic neg_r, neg_nxt;
  mul_job_t job_r, job_nxt;
  logic [95:0] acc_r, acc_nxt;
  logic signed [63:0] d_r, d_nxt;
  logic [REM_W-1:0] dm_r, dm_nxt, rem_r, rem_nxt;
  logic [QB-1:0] q_r, q_nxt;
  logic signed [15:0] tres_r, tres_nxt;
  logic signed [15:0] last_temp_r, last_temp_nxt;
  logic heater_on_r, heater_on_nxt;
  logic fault_r, fault_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_temp_r, out_temp_nxt;
  logic out_heat_r, out_heat_nxt;
  logic out_fault_r, out_fault_nxt;
  logic [47:0] coef_a_r, coef_b_r, coef_c_r;
  logic [13:0] target_r;
  logic [10:0] band_r;
  logic enable_r;

  logic [31:0] mul_a, mul_b;
  logic in_acc, out_load;
  logic [ADC_BITS-1:0] ln_n;
  logic [KW-1:0] ln_k;
  logic [32:0] sq_t;
  logic [31:0] sq_x;
  logic [LN_W-1:0] ln_v;
  logic [1:0] pp_sh;
  logic [95:0] pp_w;
  logic [63:0] mres;
  logic signed [63:0] mres_s;
  logic [63:0] dmag;
  logic [REM_W-1:0] r2;
  logic div_ge;
  logic signed [25:0] q_s;
  logic signed [27:0] t_w;
  logic signed [19:0] t_f;
  logic signed [16:0] tgt_s, thr_s, t17;
  logic [47:0] mag_b, mag_c;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_heat_r, out_temp_r};
  assign out_tuser  = out_fault_r;

  // shared multiplier
  assign p_nxt = mul_a * mul_b;

  assign ln_n = ln_sel_r ? adc_r
                         : ADC_BITS'(({1'b1, {ADC_BITS{1'b0}}}) - {1'b0, adc_r});

  always_comb begin
    ln_k = '0;
    for (int i = 0; i < ADC_BITS; i++) begin
      if (ln_n[i]) ln_k = KW'(i);
    end
  end

  assign sq_t = p_r[63:31];
  assign sq_x = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
  assign ln_v = {4'b0, kln_r} + {8'b0, p_r[63:32]};

  assign pp_sh = {1'b0, pidx_r[1]} + {1'b0, pidx_r[0]};
  always_comb begin
    case (pp_sh)
      2'd1:    pp_w = {p_r, 32'b0};
      2'd2:    pp_w = {p_r[31:0], 64'b0};
      default: pp_w = {32'b0, p_r};
    endcase
  end

  assign mres   = acc_r[95:32];
  assign mres_s = neg_r ? -$signed(mres) : $signed(mres);
  assign mag_b  = coef_b_r[47] ? (~coef_b_r + 48'd1) : coef_b_r;
  assign mag_c  = coef_c_r[47] ? (~coef_c_r + 48'd1) : coef_c_r;

  assign dmag   = d_r[63] ? 64'(-d_r) : 64'(d_r);
  assign r2     = {rem_r[REM_W-2:0], 1'b0};
  assign div_ge = (r2 >= dm_r);

  assign q_s = d_r[63] ? -$signed({2'b0, q_r}) : $signed({2'b0, q_r});
  assign t_w = 28'(q_s) - KELVIN_Q8 + HALF_LSB;
  assign t_f = 20'(t_w >>> 8);

  assign tgt_s = 17'(signed'(target_r));
  assign thr_s = tgt_s - $signed({6'b0, band_r});
  assign t17   = 17'(tres_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!enable_r || (in_tdata[ADC_BITS-1:0] == '0)) state_nxt = ST_FIN;
          else state_nxt = ST_LN_INIT;
        end
      end
      ST_LN_INIT: state_nxt = ST_LN_SQ;
      ST_LN_SQ: begin
        if (cnt_r == 6'd32) state_nxt = ST_LN_FR;
      end
      ST_LN_FR: state_nxt = ST_LN_ACC;
      ST_LN_ACC: state_nxt = ln_sel_r ? ST_MUL : ST_LN_INIT;
      ST_MUL: begin
        if (cnt_r == 6'd4) state_nxt = ST_MUL_WB;
      end
      ST_MUL_WB: state_nxt = (job_r == JOB_CL3) ? ST_DIV_INIT : ST_MUL;
      ST_DIV_INIT: state_nxt = (dmag <= DIV_LIM) ? ST_UPD : ST_DIV;
      ST_DIV: begin
        if (cnt_r == 6'(QB - 1)) state_nxt = ST_CONV;
      end
      ST_CONV: state_nxt = ST_UPD;
      ST_UPD: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    adc_nxt       = adc_r;
    ln_sel_nxt    = ln_sel_r;
    x_nxt         = x_r;
    frac_nxt      = frac_r;
    kln_nxt       = kln_r;
    pidx_nxt      = pidx_r;
    l_nxt         = l_r;
    l3_nxt        = l3_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    neg_nxt       = neg_r;
    job_nxt       = job_r;
    acc_nxt       = acc_r;
    d_nxt         = d_r;
    dm_nxt        = dm_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    tres_nxt      = tres_r;
    last_temp_nxt = last_temp_r;
    heater_on_nxt = heater_on_r;
    fault_nxt     = fault_r;
    out_temp_nxt  = out_temp_r;
    out_heat_nxt  = out_heat_r;
    out_fault_nxt = out_fault_r;
    mul_a         = x_r;
    mul_b         = x_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          adc_nxt    = in_tdata[ADC_BITS-1:0];
          ln_sel_nxt = 1'b0;
          fault_nxt  = 1'b0;
          if (enable_r && (in_tdata[ADC_BITS-1:0] == '0)) begin
            fault_nxt     = 1'b1;
            heater_on_nxt = 1'b0;
          end
        end
      end
      ST_LN_INIT: begin
        x_nxt    = {{(32-ADC_BITS){1'b0}}, ln_n} << (5'd31 - 5'(ln_k));
        mul_a    = 32'(ln_k);
        mul_b    = LN2_Q32;
        cnt_nxt  = '0;
        frac_nxt = '0;
      end
      ST_LN_SQ: begin
        if (cnt_r == '0) begin
          kln_nxt = p_r[35:0];
        end else begin
          frac_nxt = {frac_r[30:0], sq_t[32]};
          mul_a    = sq_x;
          mul_b    = sq_x;
        end
        cnt_nxt = cnt_r + 6'd1;
      end
      ST_LN_FR: begin
        mul_a = frac_r;
        mul_b = LN2_Q32;
      end
      ST_LN_ACC: begin
        if (!ln_sel_r) begin
          l_nxt      = ln_v + LN_1E5_Q32;
          ln_sel_nxt = 1'b1;
        end else begin
          l_nxt   = l_r - ln_v;
          ma_nxt  = {8'b0, l_r - ln_v};
          mb_nxt  = {8'b0, l_r - ln_v};
          neg_nxt = 1'b0;
          job_nxt = JOB_L2;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_MUL: begin
        mul_a    = cnt_r[1] ? {16'b0, ma_r[47:32]} : ma_r[31:0];
        mul_b    = cnt_r[0] ? {16'b0, mb_r[47:32]} : mb_r[31:0];
        pidx_nxt = cnt_r[1:0];
        if (cnt_r != '0) acc_nxt = acc_r + pp_w;
        cnt_nxt = cnt_r + 6'd1;
      end
      ST_MUL_WB: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        case (job_r)
          JOB_L2: begin
            ma_nxt  = mres[47:0];
            mb_nxt  = {8'b0, l_r};
            neg_nxt = 1'b0;
            job_nxt = JOB_L3;
          end
          JOB_L3: begin
            l3_nxt  = mres[47:0];
            ma_nxt  = mag_b;
            mb_nxt  = {8'b0, l_r};
            neg_nxt = coef_b_r[47];
            job_nxt = JOB_BL;
          end
          JOB_BL: begin
            d_nxt   = 64'(signed'(coef_a_r)) + mres_s;
            ma_nxt  = mag_c;
            mb_nxt  = l3_r;
            neg_nxt = coef_c_r[47];
            job_nxt = JOB_CL3;
          end
          default: begin
            d_nxt = d_r + mres_s;
          end
        endcase
      end
      ST_DIV_INIT: begin
        dm_nxt  = dmag[REM_W-1:0];
        rem_nxt = REM_INIT;
        q_nxt   = '0;
        cnt_nxt = '0;
        tres_nxt = d_r[63] ? 16'sh8000 : 16'sh7FFF;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? (r2 - dm_r) : r2;
        q_nxt   = {q_r[QB-2:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
      end
      ST_CONV: begin
        if (t_f > 20'sd32767) tres_nxt = 16'sh7FFF;
        else if (t_f < -20'sd32768) tres_nxt = 16'sh8000;
        else tres_nxt = 16'(t_f);
      end
      ST_UPD: begin
        last_temp_nxt = tres_r;
        fault_nxt     = 1'b0;
        if (!heater_on_r && (t17 < thr_s)) heater_on_nxt = 1'b1;
        else if (heater_on_r && (t17 >= tgt_s)) heater_on_nxt = 1'b0;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = last_temp_r;
          out_heat_nxt  = heater_on_r;
          out_fault_nxt = fault_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      heater_on_r <= 1'b0;
      last_temp_r <= '0;
      coef_a_r    <= '0;
      coef_b_r    <= '0;
      coef_c_r    <= '0;
      target_r    <= '0;
      band_r      <= 11'd80;
      enable_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      heater_on_r <= heater_on_nxt;
      last_temp_r <= last_temp_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COEF_A: coef_a_r <= cfg_wdata;
          CFG_COEF_B: coef_b_r <= cfg_wdata;
          CFG_COEF_C: coef_c_r <= cfg_wdata;
          CFG_TARGET: target_r <= cfg_wdata[13:0];
          CFG_BAND:   band_r   <= cfg_wdata[10:0];
          CFG_ENABLE: enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    adc_r       <= adc_nxt;
    ln_sel_r    <= ln_sel_nxt;
    x_r         <= x_nxt;
    frac_r      <= frac_nxt;
    kln_r       <= kln_nxt;
    p_r         <= p_nxt;
    pidx_r      <= pidx_nxt;
    l_r         <= l_nxt;
    l3_r        <= l3_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    neg_r       <= neg_nxt;
    job_r       <= job_nxt;
    acc_r       <= acc_nxt;
    d_r         <= d_nxt;
    dm_r        <= dm_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    tres_r      <= tres_nxt;
    fault_r     <= fault_nxt;
    out_temp_r  <= out_temp_nxt;
    out_heat_r  <= out_heat_nxt;
    out_fault_r <= out_fault_nxt;
  end

  a_fault_no_heat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> !out_heat_r)
    else $error("fault item reports heater on");

  a_zero_sample_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && enable_r && (in_tdata[ADC_BITS-1:0] == '0) |=> !heater_on_r)
    else $error("zero sample left heater on");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < dm_r)
    else $error("divider remainder out of range");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < 6'(QB))
    else $error("divider step count overrun");

  a_sq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LN_SQ |-> cnt_r <= 6'd32)
    else $error("log loop step count overrun");

endmodule
`default_nettype wire
